>>> hw/rtl/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants for the TLS server-name extractor
// Parse phases, result status codes, ClientHello layout constants and the
// phase transition taken when a skipped field runs out.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int POS_W = 17;
    localparam int LEN_W = 16;

    // ClientHello layout
    localparam logic [POS_W:0]   PRE_SESSION_BYTES   = 18'd43;
    localparam logic [LEN_W-1:0] SESSION_LEN_BYTES   = 16'd1;
    localparam logic [LEN_W-1:0] SUITES_LEN_BYTES    = 16'd2;
    localparam logic [LEN_W-1:0] COMP_LEN_BYTES      = 16'd1;
    localparam logic [LEN_W-1:0] EXT_TOTAL_LEN_BYTES = 16'd2;
    localparam logic [LEN_W-1:0] EXT_HDR_FIELD_BYTES = 16'd2;
    localparam logic [LEN_W-1:0] NAME_LEN_BYTES      = 16'd2;
    localparam logic [LEN_W-1:0] SNI_SKIP_BYTES      = 16'd3;
    localparam logic [LEN_W-1:0] SNI_EXT_TYPE        = 16'd0;

    // Header positions of the record length
    localparam logic [POS_W-1:0] REC_LEN_HI_POS = 17'd3;
    localparam logic [POS_W-1:0] REC_LEN_LO_POS = 17'd4;

    typedef enum logic [1:0] {
        STATUS_NAME  = 2'd0,
        STATUS_NONE  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_PREFIX     = 4'd1,
        PH_SESS_LEN   = 4'd2,
        PH_SESS_SKIP  = 4'd3,
        PH_SUITE_LEN  = 4'd4,
        PH_SUITE_SKIP = 4'd5,
        PH_COMP_LEN   = 4'd6,
        PH_COMP_SKIP  = 4'd7,
        PH_EXT_TOTAL  = 4'd8,
        PH_EXT_TYPE   = 4'd9,
        PH_EXT_LEN    = 4'd10,
        PH_EXT_SKIP   = 4'd11,
        PH_SNI_SKIP   = 4'd12,
        PH_NAME_LEN   = 4'd13,
        PH_NAME       = 4'd14,
        PH_DONE       = 4'd15
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [LEN_W-1:0] left;
        logic             clr_acc;
    } skip_res_t;

    // Where to go once a skipped field has been consumed
    function automatic skip_res_t skip_done(input phase_t phase);
        skip_res_t r;
        r.clr_acc = 1'b1;
        case (phase) inside
            PH_SESS_SKIP:
            begin
                r.phase = PH_SUITE_LEN;
                r.left  = SUITES_LEN_BYTES;
            end
            PH_SUITE_SKIP:
            begin
                r.phase = PH_COMP_LEN;
                r.left  = COMP_LEN_BYTES;
            end
            PH_COMP_SKIP:
            begin
                r.phase   = PH_EXT_TOTAL;
                r.left    = EXT_TOTAL_LEN_BYTES;
                r.clr_acc = 1'b0;
            end
            PH_EXT_TOTAL, PH_EXT_SKIP:
            begin
                r.phase = PH_EXT_TYPE;
                r.left  = EXT_HDR_FIELD_BYTES;
            end
            default:
            begin
                r.phase = PH_NAME_LEN;
                r.left  = NAME_LEN_BYTES;
            end
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/tls_sni_extractor_top.sv
// ----------------------------------------------------------------------------
// tls_sni_extractor_top: server-name extraction from a TLS ClientHello
// Walks the record byte by byte and emits the SNI host name bytes, or a
// single not-found or empty-name status per record.
// ----------------------------------------------------------------------------
// One record byte per beat, one beat per cycle sustained while no result is
// held by out_stall. Each byte is held in an input register, the parser
// state update and result decode are combinational, and any result goes to
// an output register. A beat carrying
// record_start restarts the parser on that byte. Each record yields either
// its name bytes (the last one flagged), or one status beat: no server name
// if the record ends first, empty name for a zero-length name. Bytes outside
// a record are absorbed with no result. in_stall rises only while a result
// is held by out_stall and the next byte waits in the input register.
// ----------------------------------------------------------------------------
module tls_sni_extractor_top
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       record_start,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] name_byte,
    output logic [1:0] status,
    output logic       last_of_name
);

    localparam int POS_W = tse_pkg::POS_W;
    localparam int LEN_W = tse_pkg::LEN_W;

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;

    // parser state
    tse_pkg::phase_t  phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] rec_len_reg, rec_len_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [LEN_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0] ext_reg, ext_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] name_byte_reg, name_byte_next;
    logic [1:0] status_reg, status_next;
    logic       last_reg, last_next;

    logic             advance;
    logic             upd;
    tse_pkg::phase_t  eff_phase;
    logic [POS_W-1:0] eff_pos;
    logic [LEN_W-1:0] eff_rec_len;
    logic [LEN_W-1:0] eff_left;
    logic [LEN_W-1:0] eff_acc;
    logic [LEN_W-1:0] eff_ext;
    logic [LEN_W-1:0] rec_len_upd;
    logic [LEN_W-1:0] acc_shift;
    logic [POS_W:0]   pos_plus;
    logic             field_fin;
    logic             at_end;
    logic             emit_name;
    logic             emit_empty;
    logic             res_valid;
    logic             res_last;
    tse_pkg::skip_res_t sd;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            byte_reg  <= data_byte;
            start_reg <= record_start;
        end
    end

    // A start beat sees the state as just after reset, in the prefix phase
    always_comb
    begin
        if (start_reg)
        begin
            eff_phase   = tse_pkg::PH_PREFIX;
            eff_pos     = '0;
            eff_rec_len = '0;
            eff_left    = '0;
            eff_acc     = '0;
            eff_ext     = '0;
        end
        else
        begin
            eff_phase   = phase_reg;
            eff_pos     = pos_reg;
            eff_rec_len = rec_len_reg;
            eff_left    = left_reg;
            eff_acc     = acc_reg;
            eff_ext     = ext_reg;
        end
    end

    assign upd = advance && (start_reg || (phase_reg != tse_pkg::PH_IDLE
                                           && phase_reg != tse_pkg::PH_DONE));

    always_comb
    begin
        rec_len_upd = eff_rec_len;
        if (eff_phase == tse_pkg::PH_PREFIX)
        begin
            if (eff_pos == tse_pkg::REC_LEN_HI_POS)
            begin
                rec_len_upd = {byte_reg, 8'h00};
            end
            else if (eff_pos == tse_pkg::REC_LEN_LO_POS)
            begin
                rec_len_upd = eff_rec_len | {8'h00, byte_reg};
            end
        end
    end

    assign acc_shift = {eff_acc[7:0], byte_reg};
    assign pos_plus  = {1'b0, eff_pos} + {{POS_W{1'b0}}, 1'b1};
    assign field_fin = (eff_left <= {{(LEN_W-1){1'b0}}, 1'b1});
    assign at_end    = (eff_pos >= tse_pkg::REC_LEN_LO_POS)
                       && (eff_pos == tse_pkg::REC_LEN_LO_POS + {1'b0, rec_len_upd});

    assign emit_name  = (eff_phase == tse_pkg::PH_NAME);
    assign emit_empty = (eff_phase == tse_pkg::PH_NAME_LEN) && field_fin
                        && (acc_shift == '0);
    assign res_valid  = emit_name || emit_empty || at_end;
    assign res_last   = emit_name ? (field_fin || at_end) : 1'b1;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        rec_len_next = rec_len_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        ext_next     = ext_reg;
        sd           = tse_pkg::skip_done(eff_phase);
        if (upd)
        begin
            phase_next   = eff_phase;
            pos_next     = pos_plus[POS_W-1:0];
            rec_len_next = rec_len_upd;
            left_next    = eff_left;
            acc_next     = eff_acc;
            ext_next     = eff_ext;
            unique case (eff_phase) inside
                tse_pkg::PH_PREFIX:
                begin
                    if (pos_plus >= tse_pkg::PRE_SESSION_BYTES)
                    begin
                        phase_next = tse_pkg::PH_SESS_LEN;
                        left_next  = tse_pkg::SESSION_LEN_BYTES;
                        acc_next   = '0;
                    end
                end
                tse_pkg::PH_SESS_LEN, tse_pkg::PH_SUITE_LEN, tse_pkg::PH_COMP_LEN,
                tse_pkg::PH_EXT_TYPE, tse_pkg::PH_EXT_LEN, tse_pkg::PH_NAME_LEN:
                begin
                    acc_next = acc_shift;
                    if (!field_fin)
                    begin
                        left_next = eff_left - 1'b1;
                    end
                    else
                    begin
                        left_next = '0;
                        unique case (eff_phase) inside
                            tse_pkg::PH_SESS_LEN, tse_pkg::PH_SUITE_LEN,
                            tse_pkg::PH_COMP_LEN:
                            begin
                                // skip phase follows its length phase
                                if (eff_phase == tse_pkg::PH_SESS_LEN)
                                begin
                                    sd = tse_pkg::skip_done(tse_pkg::PH_SESS_SKIP);
                                    phase_next = tse_pkg::PH_SESS_SKIP;
                                end
                                else if (eff_phase == tse_pkg::PH_SUITE_LEN)
                                begin
                                    sd = tse_pkg::skip_done(tse_pkg::PH_SUITE_SKIP);
                                    phase_next = tse_pkg::PH_SUITE_SKIP;
                                end
                                else
                                begin
                                    sd = tse_pkg::skip_done(tse_pkg::PH_COMP_SKIP);
                                    phase_next = tse_pkg::PH_COMP_SKIP;
                                end
                                left_next = acc_shift;
                                if (acc_shift == '0)
                                begin
                                    phase_next = sd.phase;
                                    left_next  = sd.left;
                                    if (sd.clr_acc)
                                    begin
                                        acc_next = '0;
                                    end
                                end
                            end
                            tse_pkg::PH_EXT_TYPE:
                            begin
                                ext_next   = acc_shift;
                                phase_next = tse_pkg::PH_EXT_LEN;
                                left_next  = tse_pkg::EXT_HDR_FIELD_BYTES;
                                acc_next   = '0;
                            end
                            tse_pkg::PH_EXT_LEN:
                            begin
                                sd = tse_pkg::skip_done(tse_pkg::PH_EXT_SKIP);
                                if (eff_ext == tse_pkg::SNI_EXT_TYPE)
                                begin
                                    phase_next = tse_pkg::PH_SNI_SKIP;
                                    left_next  = tse_pkg::SNI_SKIP_BYTES;
                                end
                                else if (acc_shift == '0)
                                begin
                                    phase_next = sd.phase;
                                    left_next  = sd.left;
                                    acc_next   = '0;
                                end
                                else
                                begin
                                    phase_next = tse_pkg::PH_EXT_SKIP;
                                    left_next  = acc_shift;
                                end
                            end
                            default:
                            begin
                                // name length; an empty name is closed below
                                if (acc_shift != '0)
                                begin
                                    phase_next = tse_pkg::PH_NAME;
                                    left_next  = acc_shift;
                                end
                            end
                        endcase
                    end
                end
                tse_pkg::PH_NAME:
                begin
                    left_next = field_fin ? '0 : eff_left - 1'b1;
                end
                tse_pkg::PH_SESS_SKIP, tse_pkg::PH_SUITE_SKIP, tse_pkg::PH_COMP_SKIP,
                tse_pkg::PH_EXT_TOTAL, tse_pkg::PH_EXT_SKIP, tse_pkg::PH_SNI_SKIP:
                begin
                    if (field_fin)
                    begin
                        phase_next = sd.phase;
                        left_next  = sd.left;
                        if (sd.clr_acc)
                        begin
                            acc_next = '0;
                        end
                    end
                    else
                    begin
                        left_next = eff_left - 1'b1;
                    end
                end
                tse_pkg::PH_IDLE, tse_pkg::PH_DONE:
                begin
                    // not reached while updating
                end
            endcase
            if (res_valid && res_last)
            begin
                phase_next = tse_pkg::PH_DONE;
            end
        end
    end

    // result decode
    always_comb
    begin
        name_byte_next = 8'h00;
        last_next      = res_last;
        if (emit_name)
        begin
            name_byte_next = byte_reg;
            status_next    = tse_pkg::STATUS_NAME;
        end
        else if (emit_empty)
        begin
            status_next = tse_pkg::STATUS_EMPTY;
        end
        else
        begin
            status_next = tse_pkg::STATUS_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tse_pkg::PH_IDLE;
            pos_reg     <= '0;
            rec_len_reg <= '0;
            left_reg    <= '0;
            acc_reg     <= '0;
            ext_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            rec_len_reg <= rec_len_next;
            left_reg    <= left_next;
            acc_reg     <= acc_next;
            ext_reg     <= ext_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= upd && res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            name_byte_reg <= name_byte_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign name_byte    = name_byte_reg;
    assign status       = status_reg;
    assign last_of_name = last_reg;

    // closing beat of a record parks the parser
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && res_valid && res_last) |=> (phase_reg == tse_pkg::PH_DONE))
        else $error("parser not parked after closing beat");

    a_status_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != tse_pkg::STATUS_NAME) |-> last_of_name)
        else $error("status beat without last flag");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("undefined status code");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled with output free");

    a_idle_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != tse_pkg::PH_IDLE) |=> (phase_reg != tse_pkg::PH_IDLE))
        else $error("parser fell back to idle");

endmodule

>>> test/tls_sni_extractor_top_tb.sv
// ----------------------------------------------------------------------------
// tls_sni_extractor_top_tb: server-name extraction from TLS ClientHello bytes
// Feeds whole and broken ClientHello records byte by byte, predicts the name
// bytes and status beats of each record, and checks every result beat in
// order. Directed records cover the special cases, then random records run
// under several idling mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tls_sni_extractor_top_tb;

    // ClientHello layout as the parser sees it
    localparam int HELLO_PREFIX_LEN = 43;
    localparam int SESS_LEN_W       = 1;
    localparam int SUITES_LEN_W     = 2;
    localparam int COMP_LEN_W       = 1;
    localparam int EXT_TOTAL_W      = 2;
    localparam int EXT_FIELD_W      = 2;
    localparam int NAME_LEN_W       = 2;
    localparam int SNI_SKIP_LEN     = 3;
    localparam int SNI_TYPE         = 0;
    localparam int REC_HDR_LEN      = 5;
    localparam int LEN_HI_POS       = 3;
    localparam int LEN_LO_POS       = 4;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_MIX = 125;

    typedef struct packed {
        logic [7:0]       name;
        tse_pkg::status_t st;
        logic             last;
    } sni_beat_t;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte    = 8'h00;
    logic       record_start = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [7:0] name_byte;
    logic [1:0] status;
    logic       last_of_name;

    int cycles        = 0;
    int hold_until    = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int errors        = 0;
    int parsed_items  = 0;

    sni_beat_t  sni_q[$];
    logic [7:0] hello_q[$];

    // Parser state of the prediction
    tse_pkg::phase_t ph       = tse_pkg::PH_IDLE;
    logic [16:0]     pos      = '0;
    logic [15:0]     rec_len  = '0;
    logic [15:0]     left     = '0;
    logic [15:0]     acc      = '0;
    logic [15:0]     ext_type = '0;

    tls_sni_extractor_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .record_start (record_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .name_byte    (name_byte),
        .status       (status),
        .last_of_name (last_of_name)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, plus a hold-off window set by the pressure test
    always @(negedge clk)
    begin
        out_stall <= (cycles < hold_until) || ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge clk)
    begin
        sni_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sni_q.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result: byte %h status %0d last %b",
                             name_byte, status, last_of_name);
                errors++;
            end
            else
            begin
                want = sni_q.pop_front();
                if (name_byte !== want.name || status !== want.st
                    || last_of_name !== want.last)
                begin
                    if (errors < 10)
                        $display("mismatch (byte status last): expected %h %0d %b, got %h %0d %b",
                                 want.name, want.st, want.last,
                                 name_byte, status, last_of_name);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void start_field(input tse_pkg::phase_t p, input logic [15:0] n);
        ph   = p;
        left = n;
        acc  = '0;
    endfunction

    function automatic void field_skipped(input tse_pkg::phase_t p);
        case (p) inside
            tse_pkg::PH_SESS_SKIP:  start_field(tse_pkg::PH_SUITE_LEN, 16'(SUITES_LEN_W));
            tse_pkg::PH_SUITE_SKIP: start_field(tse_pkg::PH_COMP_LEN, 16'(COMP_LEN_W));
            tse_pkg::PH_COMP_SKIP:
            begin
                // keep the accumulator
                ph   = tse_pkg::PH_EXT_TOTAL;
                left = 16'(EXT_TOTAL_W);
            end
            tse_pkg::PH_EXT_TOTAL, tse_pkg::PH_EXT_SKIP:
                start_field(tse_pkg::PH_EXT_TYPE, 16'(EXT_FIELD_W));
            default:
                start_field(tse_pkg::PH_NAME_LEN, 16'(NAME_LEN_W));
        endcase
    endfunction

    function automatic void skip_over(input tse_pkg::phase_t p, input logic [15:0] n);
        if (n == 0)
            field_skipped(p);
        else
        begin
            ph   = p;
            left = n;
        end
    endfunction

    // Act on a finished length field; return 1 for an empty name
    function automatic logic length_complete();
        case (ph)
            tse_pkg::PH_SESS_LEN:  skip_over(tse_pkg::PH_SESS_SKIP, acc);
            tse_pkg::PH_SUITE_LEN: skip_over(tse_pkg::PH_SUITE_SKIP, acc);
            tse_pkg::PH_COMP_LEN:  skip_over(tse_pkg::PH_COMP_SKIP, acc);
            tse_pkg::PH_EXT_TYPE:
            begin
                ext_type = acc;
                start_field(tse_pkg::PH_EXT_LEN, 16'(EXT_FIELD_W));
            end
            tse_pkg::PH_EXT_LEN:
            begin
                if (ext_type == SNI_TYPE)
                begin
                    ph   = tse_pkg::PH_SNI_SKIP;
                    left = 16'(SNI_SKIP_LEN);
                end
                else
                    skip_over(tse_pkg::PH_EXT_SKIP, acc);
            end
            default:
            begin
                if (acc == 0)
                    return 1'b1;
                ph   = tse_pkg::PH_NAME;
                left = acc;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void predict_sni(input logic [7:0] b, input logic s);
        logic      is_name;
        logic      is_empty;
        logic      is_last;
        logic      rec_end;
        sni_beat_t r;
        is_name  = 1'b0;
        is_empty = 1'b0;
        is_last  = 1'b0;
        if (s)
        begin
            ph       = tse_pkg::PH_PREFIX;
            pos      = '0;
            rec_len  = '0;
            left     = '0;
            acc      = '0;
            ext_type = '0;
        end
        else if (ph == tse_pkg::PH_IDLE || ph == tse_pkg::PH_DONE)
            return;
        parsed_items++;

        case (ph) inside
            tse_pkg::PH_PREFIX:
            begin
                if (pos == LEN_HI_POS)
                    rec_len = {b, 8'h00};
                else if (pos == LEN_LO_POS)
                    rec_len = rec_len | {8'h00, b};
                if (pos + 1 >= HELLO_PREFIX_LEN)
                    start_field(tse_pkg::PH_SESS_LEN, 16'(SESS_LEN_W));
            end
            tse_pkg::PH_SESS_LEN, tse_pkg::PH_SUITE_LEN, tse_pkg::PH_COMP_LEN,
            tse_pkg::PH_EXT_TYPE, tse_pkg::PH_EXT_LEN, tse_pkg::PH_NAME_LEN:
            begin
                acc = {acc[7:0], b};
                if (left <= 1)
                begin
                    left     = '0;
                    is_empty = length_complete();
                end
                else
                    left--;
            end
            tse_pkg::PH_NAME:
            begin
                is_name = 1'b1;
                if (left <= 1)
                begin
                    left    = '0;
                    is_last = 1'b1;
                end
                else
                    left--;
            end
            default:
            begin
                if (left <= 1)
                begin
                    left = '0;
                    field_skipped(ph);
                end
                else
                    left--;
            end
        endcase

        rec_end = (pos >= LEN_LO_POS) && ({1'b0, pos} == {2'b00, rec_len} + 18'd4);
        pos     = pos + 1'b1;

        if (is_name)
        begin
            is_last = is_last || rec_end;
            if (is_last)
                ph = tse_pkg::PH_DONE;
            r.name = b;
            r.st   = tse_pkg::STATUS_NAME;
            r.last = is_last;
            sni_q.push_back(r);
        end
        else if (is_empty || rec_end)
        begin
            ph     = tse_pkg::PH_DONE;
            r.name = 8'h00;
            r.st   = is_empty ? tse_pkg::STATUS_EMPTY : tse_pkg::STATUS_NONE;
            r.last = 1'b1;
            sni_q.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic send_byte(input logic [7:0] b, input logic s);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        record_start <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_sni(b, s);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sni_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void push_field(input int value, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            hello_q.push_back(8'((value >> (8 * i)) & 8'hFF));
    endfunction

    function automatic void push_random(input int n);
        repeat (n) hello_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Well-formed ClientHello; a negative name length leaves out the SNI extension
    function automatic void build_hello(input int sess_n, input int suite_n, input int comp_n,
                                        input int other_exts, input int name_len);
        int ext_n;
        hello_q = {};
        hello_q.push_back(8'h16);
        push_random(HELLO_PREFIX_LEN - 1);
        push_field(sess_n, SESS_LEN_W);
        push_random(sess_n);
        push_field(suite_n, SUITES_LEN_W);
        push_random(suite_n);
        push_field(comp_n, COMP_LEN_W);
        push_random(comp_n);
        push_field($urandom_range(0, 16'hFFFF), EXT_TOTAL_W);
        repeat (other_exts)
        begin
            ext_n = $urandom_range(0, 4);
            push_field($urandom_range(1, 16'hFFFF), EXT_FIELD_W);
            push_field(ext_n, EXT_FIELD_W);
            push_random(ext_n);
        end
        if (name_len >= 0)
        begin
            push_field(SNI_TYPE, EXT_FIELD_W);
            push_field($urandom_range(0, 16'hFFFF), EXT_FIELD_W);
            push_random(SNI_SKIP_LEN);
            push_field(name_len, NAME_LEN_W);
            push_random(name_len);
        end
    endfunction

    function automatic int exact_len();
        return hello_q.size() - REC_HDR_LEN;
    endfunction

    // Send the record with the given length; cut > 0 stops after that many bytes
    task automatic send_hello(input int len, input int cut);
        int n;
        hello_q[LEN_HI_POS] = 8'((len >> 8) & 8'hFF);
        hello_q[LEN_LO_POS] = 8'(len & 8'hFF);
        if (cut == 0)
            while (hello_q.size() < len + REC_HDR_LEN)
                hello_q.push_back(8'($urandom_range(0, 255)));
        n = (cut > 0 && cut < hello_q.size()) ? cut : hello_q.size();
        for (int i = 0; i < n; i++)
            send_byte(hello_q[i], i == 0);
    endtask

    task automatic send_trailing(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_ignored_bytes();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_trailing(3);
        settle();
    endtask

    task automatic test_short_records();
        // zero record length ends at the last header byte
        hello_q = {};
        push_random(REC_HDR_LEN);
        send_hello(0, 0);
        send_trailing(2);
        // end inside the fixed prefix
        hello_q = {};
        push_random(20);
        send_hello(10, 0);
        // end inside a maximal session skip
        build_hello(0, 2, 1, 0, -1);
        hello_q[HELLO_PREFIX_LEN] = 8'hFF;
        send_hello(exact_len(), 0);
        // end inside a maximal suites skip
        build_hello(0, 2, 1, 0, -1);
        hello_q[HELLO_PREFIX_LEN + 1] = 8'hFF;
        hello_q[HELLO_PREFIX_LEN + 2] = 8'hFF;
        send_hello(exact_len(), 0);
        // whole record walked with no server name
        build_hello(2, 4, 1, 2, -1);
        send_hello(exact_len(), 0);
        settle();
    endtask

    task automatic test_name_extraction();
        // empty session, suites and compression fields
        build_hello(0, 0, 0, 0, 3);
        hello_q[hello_q.size() - 2] = 8'h00;
        hello_q[hello_q.size() - 1] = 8'hFF;
        send_hello(exact_len(), 0);
        send_trailing(3);
        build_hello(3, 6, 2, 2, 8);
        send_hello(exact_len(), 0);
        settle();
    endtask

    task automatic test_empty_name();
        build_hello(1, 2, 1, 1, 0);
        send_hello(exact_len(), 0);
        send_trailing(2);
        settle();
    endtask

    task automatic test_truncated_name();
        build_hello(1, 2, 1, 0, 10);
        send_hello(exact_len() - 4, 0);
        // name length far past the record end
        build_hello(0, 2, 1, 1, 6);
        hello_q[hello_q.size() - 8] = 8'hFF;
        hello_q[hello_q.size() - 7] = 8'hFF;
        send_hello(exact_len(), 0);
        settle();
    endtask

    task automatic test_restart_mid_record();
        build_hello(1, 2, 1, 1, 5);
        send_hello(16'hFFFF, 50);
        // restart part way through the name
        build_hello(0, 2, 1, 0, 12);
        send_hello(exact_len(), hello_q.size() - 4);
        build_hello(2, 2, 1, 1, 4);
        send_hello(exact_len(), 0);
        settle();
    endtask

    task automatic test_random_traffic(input int in_pct, input int out_pct);
        int stop_at;
        int mode;
        int len;
        int n;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        stop_at       = parsed_items + ITEMS_PER_MIX;
        while (parsed_items < stop_at)
        begin
            mode = $urandom_range(99);
            if (mode < 72)
            begin
                build_hello(($urandom_range(9) == 0) ? $urandom_range(7, 40)
                                                     : $urandom_range(0, 4),
                            $urandom_range(0, 8), $urandom_range(0, 2),
                            $urandom_range(0, 2),
                            ($urandom_range(9) == 0) ? -1 : $urandom_range(0, 12));
                len  = exact_len();
                mode = $urandom_range(99);
                if (mode < 60)
                    send_hello(len, 0);
                else if (mode < 75)
                    send_hello($urandom_range(0, len - 1), 0);
                else if (mode < 88)
                    send_hello(len + $urandom_range(1, 10), 0);
                else
                    send_hello(len, $urandom_range(1, hello_q.size() - 1));
            end
            else if (mode < 88)
            begin
                // noise record with a short random length
                n       = $urandom_range(5, 60);
                hello_q = {};
                push_random(n);
                send_hello($urandom_range(0, n), 0);
            end
            else
                send_trailing($urandom_range(1, 4));
        end
        settle();
    endtask

    task automatic test_backpressure();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        build_hello(1, 2, 1, 1, 40);
        // hold the output long enough to fill the block and stall its input
        hold_until = cycles + 150;
        send_hello(exact_len(), 0);
        settle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ignored_bytes();
        test_short_records();
        test_name_extraction();
        test_empty_name();
        test_truncated_name();
        test_restart_mid_record();
        test_random_traffic(0, 0);
        test_random_traffic(81, 0);
        test_random_traffic(0, 81);
        test_random_traffic(38, 38);
        test_backpressure();

        @(negedge clk);
        if (errors == 0 && sni_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
